// ===== sv/first_fit_block_allocator_macros.svh =====
// Assertion macros for the first-fit block allocator.
// Define NO_ASSERTIONS to compile them away.
`ifndef FIRST_FIT_BLOCK_ALLOCATOR_MACROS_SVH
`define FIRST_FIT_BLOCK_ALLOCATOR_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, checked outside reset.
`define FFBA_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked outside reset.
`define FFBA_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`else

`define FFBA_ASSERT_SAME(lbl, clk, rst, ante, cons, msg)
`define FFBA_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)

`endif

`endif

// ===== sv/ffba_pkg.sv =====
// ---------------------------------------------------------------------------
// ffba_pkg
// Shared constants, codes and types of the first-fit block allocator.
// ---------------------------------------------------------------------------
package ffba_pkg;

   localparam int MAX_BLOCKS = 8;
   localparam int SIZE_BITS  = 16;
   localparam int IDX_BITS   = 3;
   localparam int CNT_BITS   = 4;

   localparam logic [CNT_BITS-1:0] NUM_BLOCKS_RESET = CNT_BITS'(8);
   localparam logic [CNT_BITS-1:0] MAX_BLOCKS_CNT   = CNT_BITS'(MAX_BLOCKS);

   localparam logic CMD_LOAD    = 1'b0;
   localparam logic CMD_REQUEST = 1'b1;

   typedef enum logic [0:0] {
      ENG_IDLE,
      ENG_SCAN
   } eng_state_type;

   typedef struct packed {
      logic                granted;
      logic [IDX_BITS-1:0] block;
      logic                last;
   } result_type;

endpackage

// ===== sv/ffba_engine.sv =====
// ---------------------------------------------------------------------------
// ffba_engine
// Free-size table in a registered-read memory plus the scan sequencer:
// loads write an entry directly, requests read entries in index order and
// write the first fitting one back reduced by the request.
// ---------------------------------------------------------------------------
module ffba_engine
   import ffba_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic                 req_cmd,
   input  logic [2:0]           req_block_index,
   input  logic [15:0]          req_size_value,
   input  logic                 req_batch_end,
   input  logic [CNT_BITS-1:0]  num_blocks,
   input  logic                 out_free,
   output logic                 res_valid,
   output result_type           res
);

   logic [SIZE_BITS-1:0] mem [MAX_BLOCKS];

   eng_state_type         state_ff, state_in;
   logic [IDX_BITS-1:0]   idx_ff, idx_in;
   logic [CNT_BITS-1:0]   limit_ff, limit_in;
   logic [SIZE_BITS-1:0]  size_ff, size_in;
   logic                  last_ff, last_in;
   logic                  empty_ff, empty_in;
   logic [SIZE_BITS-1:0]  rd_data_ff;

   logic                  accept;
   logic                  start;
   logic [CNT_BITS-1:0]   lim_clamp;
   logic                  fit;
   logic                  at_end;
   logic                  done;
   logic                  emit;
   logic                  advance;

   logic                  rd_en;
   logic [IDX_BITS-1:0]   rd_addr;
   logic                  wr_en;
   logic [IDX_BITS-1:0]   wr_addr;
   logic [SIZE_BITS-1:0]  wr_data;

   assign req_stall = (state_ff != ENG_IDLE);
   assign accept    = req_valid && (state_ff == ENG_IDLE);
   assign start     = accept && (req_cmd == CMD_REQUEST);
   assign lim_clamp = (num_blocks > MAX_BLOCKS_CNT) ? MAX_BLOCKS_CNT : num_blocks;

   // rd_data_ff holds the entry at idx_ff while scanning
   assign fit     = rd_data_ff >= size_ff;
   assign at_end  = (CNT_BITS'(idx_ff) + CNT_BITS'(1)) == limit_ff;
   assign done    = empty_ff || fit || at_end;
   assign emit    = (state_ff == ENG_SCAN) && done && out_free;
   assign advance = (state_ff == ENG_SCAN) && !done;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ENG_IDLE: begin
            if (start) begin
               state_in = ENG_SCAN;
            end
         end
         ENG_SCAN: begin
            if (emit) begin
               state_in = ENG_IDLE;
            end
         end
         default: state_in = ENG_IDLE;
      endcase
   end

   // memory ports and result
   always_comb begin
      rd_en   = 1'b0;
      rd_addr = '0;
      wr_en   = 1'b0;
      wr_addr = '0;
      wr_data = '0;
      case (state_ff)
         ENG_IDLE: begin
            rd_en   = start;
            wr_en   = accept && (req_cmd == CMD_LOAD);
            wr_addr = req_block_index;
            wr_data = req_size_value;
         end
         ENG_SCAN: begin
            rd_en   = advance;
            rd_addr = idx_ff + IDX_BITS'(1);
            wr_en   = emit && fit && !empty_ff;
            wr_addr = idx_ff;
            wr_data = rd_data_ff - size_ff;
         end
         default: begin
            rd_en = 1'b0;
         end
      endcase
   end

   assign res_valid   = emit;
   assign res.granted = fit && !empty_ff;
   assign res.block   = (fit && !empty_ff) ? idx_ff : '0;
   assign res.last    = last_ff;

   always_comb begin
      idx_in   = idx_ff;
      limit_in = limit_ff;
      size_in  = size_ff;
      last_in  = last_ff;
      empty_in = empty_ff;
      if (start) begin
         idx_in   = '0;
         limit_in = lim_clamp;
         size_in  = req_size_value;
         last_in  = req_batch_end;
         empty_in = (lim_clamp == '0);
      end else if (advance) begin
         idx_in = idx_ff + IDX_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ENG_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff   <= idx_in;
      limit_ff <= limit_in;
      size_ff  <= size_in;
      last_ff  <= last_in;
      empty_ff <= empty_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

endmodule

// ===== sv/first_fit_block_allocator.sv =====
// ---------------------------------------------------------------------------
// first_fit_block_allocator
// First-fit allocator over a table of per-block free sizes.
// ---------------------------------------------------------------------------
// Usage:
//   req_* channel (valid/stall): cmd 0 loads req_size_value as the free size
//   of block req_block_index and returns nothing; cmd 1 requests
//   req_size_value and returns one rsp_* beat.
//   rsp_* channel (valid/stall): granted, alloc_block (0 when not granted)
//   and batch_last, the echo of req_batch_end.
//   csr_* channel (valid/ready): writes num_blocks, the count of blocks
//   scanned from index zero; write only while the block is idle.
// Scan:
//   A load writes its entry directly. A request scans at most N entries,
//   N = min(num_blocks, 8): the table memory is read one entry per cycle
//   and its read port sets the pace; a hit ends the scan early and writes
//   the reduced size back in the cycle the result is registered.
// Reset: num_blocks returns to 8, the scan sequencer and the output beat
//   are cleared. Table entries hold nothing until loaded.
// Stall: a result waits in the output register; the next item is still
//   taken, and its scan holds at its decision until the register frees.
// ---------------------------------------------------------------------------
`include "first_fit_block_allocator_macros.svh"

module first_fit_block_allocator
   import ffba_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_cmd,
   input  logic [2:0]  req_block_index,
   input  logic [15:0] req_size_value,
   input  logic        req_batch_end,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_granted,
   output logic [2:0]  rsp_alloc_block,
   output logic        rsp_batch_last,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [3:0]  csr_num_blocks
);

   logic [CNT_BITS-1:0] num_blocks_ff, num_blocks_in;
   logic                rsp_valid_ff, rsp_valid_in;
   result_type          rsp_data_ff, rsp_data_in;

   logic                out_free;
   logic                res_valid;
   result_type          res;

   assign csr_ready = 1'b1;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   ffba_engine u_engine (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_cmd         (req_cmd),
      .req_block_index (req_block_index),
      .req_size_value  (req_size_value),
      .req_batch_end   (req_batch_end),
      .num_blocks      (num_blocks_ff),
      .out_free        (out_free),
      .res_valid       (res_valid),
      .res             (res)
   );

   always_comb begin
      num_blocks_in = num_blocks_ff;
      if (csr_valid && csr_ready) begin
         num_blocks_in = csr_num_blocks;
      end
   end

   // load a new beat when one is produced, drop the old one once taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (res_valid) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = res;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         num_blocks_ff <= NUM_BLOCKS_RESET;
         rsp_valid_ff  <= 1'b0;
      end else begin
         num_blocks_ff <= num_blocks_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_granted     = rsp_data_ff.granted;
   assign rsp_alloc_block = rsp_data_ff.block;
   assign rsp_batch_last  = rsp_data_ff.last;

   `FFBA_ASSERT_SAME(a_no_overwrite, clock, reset, res_valid, out_free,
      "result produced while output beat still stalled")
   `FFBA_ASSERT_SAME(a_deny_zero_block, clock, reset, rsp_valid && !rsp_granted,
      rsp_alloc_block == 3'd0, "denied beat carries nonzero block")
   `FFBA_ASSERT_NEXT(a_request_busy, clock, reset,
      req_valid && !req_stall && (req_cmd == CMD_REQUEST), req_stall,
      "accepted request did not start a scan")
   `FFBA_ASSERT_SAME(a_grant_in_range, clock, reset, res_valid && res.granted,
      ({1'b0, res.block} < num_blocks_ff), "grant beyond configured block count")

endmodule
